// ===== hw/rtl/cle_pkg.sv =====
// Shared types and constants for the compacting list engine.
// No dependencies; used by every module in hw/rtl except cle_ram.
`timescale 1ns / 1ps

package cle_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int IDX_W        = 4;
   localparam int CMD_W        = 2;
   localparam int STAT_W       = 2;

   typedef enum logic [CMD_W-1:0] {
      OP_APPEND       = 2'd0,
      OP_DELETE_AT    = 2'd1,
      OP_DELETE_VALUE = 2'd2,
      OP_GET          = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_GET_WAIT,
      S_SCAN,
      S_RESP
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic append;
      logic flag_full;
      logic flag_range;
      logic get_issue;
      logic get_capture;
      logic scan_start_at;
      logic scan_start_val;
      logic scan_run;
      logic scan_finish;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   idx_valid;
      logic   scan_done;
   } sts_type;

endpackage

// ===== hw/rtl/compacting_list_engine.sv =====
// Top level of the compacting list engine: an ordered list of 32-bit words.
// Depends on cle_pkg, cle_ctrl, cle_datapath (which holds cle_ram).
//
// Usage:
//   Request word (req_valid/req_ready): req_cmd, req_value, req_index.
//   Commands: append, delete at index, delete every copy of a value, get.
//   Response word (rsp_valid/rsp_ready): rsp_read_value, rsp_count,
//   rsp_removed, rsp_status; exactly one response per request.
//   One command is in flight at a time; req_ready is high only while idle.
//   Every accepted command passes through an execute state. Append, and
//   any out-of-range / full command, then go straight to the response;
//   get first waits on the registered element store read; deletes first
//   scan the list (delete-at from the index onward, delete-value from the
//   head, also on an empty list).
//   Deletes walk the stored elements one per cycle through the single-port
//   read / single-port write element store.
//   A stalled response holds its word until rsp_ready; no new request is
//   taken meanwhile. Reset empties the list (count zero); stored words are
//   not cleared and are never read before being written.
`timescale 1ns / 1ps

module compacting_list_engine #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cle_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [cle_pkg::DATA_W-1:0] req_value,
   input  logic [cle_pkg::IDX_W-1:0]         req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cle_pkg::DATA_W-1:0] rsp_read_value,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_count,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_removed,
   output logic [cle_pkg::STAT_W-1:0]        rsp_status
);

   cle_pkg::ctl_type ctl;
   cle_pkg::sts_type sts;

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   cle_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_removed    (rsp_removed),
      .rsp_status     (rsp_status),
      .ctl            (ctl),
      .sts            (sts)
   );

endmodule

// ===== hw/rtl/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/cle_ctrl.sv =====
// Command sequencer for the compacting list engine.
// Depends on cle_pkg; drives cle_datapath through ctl_type / sts_type.
`timescale 1ns / 1ps

module cle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cle_pkg::ctl_type ctl,
   input  cle_pkg::sts_type sts
);

   cle_pkg::fsm_type state_ff;
   cle_pkg::fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cle_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cle_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = cle_pkg::S_EXEC;
            end
         end
         cle_pkg::S_EXEC: begin
            case (sts.op)
               cle_pkg::OP_GET: begin
                  state_in = sts.idx_valid ? cle_pkg::S_GET_WAIT : cle_pkg::S_RESP;
               end
               cle_pkg::OP_DELETE_AT: begin
                  state_in = sts.idx_valid ? cle_pkg::S_SCAN : cle_pkg::S_RESP;
               end
               cle_pkg::OP_DELETE_VALUE: begin
                  state_in = cle_pkg::S_SCAN;
               end
               default: begin
                  state_in = cle_pkg::S_RESP;
               end
            endcase
         end
         cle_pkg::S_GET_WAIT: begin
            state_in = cle_pkg::S_RESP;
         end
         cle_pkg::S_SCAN: begin
            if (sts.scan_done) begin
               state_in = cle_pkg::S_RESP;
            end
         end
         cle_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = cle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cle_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         cle_pkg::S_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         cle_pkg::S_EXEC: begin
            case (sts.op)
               cle_pkg::OP_APPEND: begin
                  ctl.append    = !sts.full;
                  ctl.flag_full = sts.full;
               end
               cle_pkg::OP_DELETE_AT: begin
                  ctl.scan_start_at = sts.idx_valid;
                  ctl.flag_range    = !sts.idx_valid;
               end
               cle_pkg::OP_DELETE_VALUE: begin
                  ctl.scan_start_val = 1'b1;
               end
               cle_pkg::OP_GET: begin
                  ctl.get_issue  = sts.idx_valid;
                  ctl.flag_range = !sts.idx_valid;
               end
               default: begin
                  ctl.flag_range = 1'b0;
               end
            endcase
         end
         cle_pkg::S_GET_WAIT: begin
            ctl.get_capture = 1'b1;
         end
         cle_pkg::S_SCAN: begin
            ctl.scan_run    = !sts.scan_done;
            ctl.scan_finish = sts.scan_done;
         end
         cle_pkg::S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/cle_datapath.sv =====
// Datapath: command registers, element count, scan pointers, result registers.
// Depends on cle_pkg and cle_ram; sequenced by cle_ctrl.
`timescale 1ns / 1ps

module cle_datapath #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cle_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [cle_pkg::DATA_W-1:0]   req_value,
   input  logic [cle_pkg::IDX_W-1:0]           req_index,
   output logic signed [cle_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_count,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_removed,
   output logic [cle_pkg::STAT_W-1:0]          rsp_status,
   input  cle_pkg::ctl_type                    ctl,
   output cle_pkg::sts_type                    sts
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = (CNT_W > cle_pkg::IDX_W) ? CNT_W : cle_pkg::IDX_W;

   cle_pkg::op_type            op_ff, op_in;
   logic [cle_pkg::DATA_W-1:0] value_ff, value_in;
   logic [cle_pkg::IDX_W-1:0]  index_ff, index_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]           gone_ff, gone_in;
   logic                       pend_ff, pend_in;
   logic [ADDR_W-1:0]          pend_pos_ff, pend_pos_in;
   logic                       mode_at_ff, mode_at_in;
   logic [cle_pkg::DATA_W-1:0] rval_ff, rval_in;
   logic [CNT_W-1:0]           removed_ff, removed_in;
   cle_pkg::status_type        status_ff, status_in;

   logic [CMP_W-1:0]           idx_wide;
   logic [ADDR_W-1:0]          idx_addr;
   logic                       issue;
   logic                       drop;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [cle_pkg::DATA_W-1:0] ram_wdata;
   logic [cle_pkg::DATA_W-1:0] ram_rdata;

   assign idx_wide = CMP_W'(index_ff);
   assign idx_addr = idx_wide[ADDR_W-1:0];

   assign sts.op        = op_ff;
   assign sts.full      = (count_ff == CNT_W'(CAPACITY));
   assign sts.idx_valid = (idx_wide < CMP_W'(count_ff));
   assign sts.scan_done = !pend_ff && (rd_ptr_ff >= count_ff);

   always_comb begin
      op_in       = op_ff;
      value_in    = value_ff;
      index_in    = index_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      gone_in     = gone_ff;
      pend_in     = pend_ff;
      pend_pos_in = pend_pos_ff;
      mode_at_in  = mode_at_ff;
      rval_in     = rval_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      ram_we      = 1'b0;
      ram_waddr   = count_ff[ADDR_W-1:0];
      ram_wdata   = value_ff;
      ram_raddr   = rd_ptr_ff[ADDR_W-1:0];
      issue       = 1'b0;
      drop        = 1'b0;

      if (ctl.load) begin
         op_in      = cle_pkg::op_type'(req_cmd);
         value_in   = req_value;
         index_in   = req_index;
         rval_in    = '0;
         removed_in = '0;
         status_in  = cle_pkg::ST_OK;
      end
      if (ctl.append) begin
         ram_we   = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.flag_full) begin
         status_in = cle_pkg::ST_FULL;
      end
      if (ctl.flag_range) begin
         status_in = cle_pkg::ST_RANGE;
      end
      if (ctl.get_issue) begin
         ram_raddr = idx_addr;
      end
      if (ctl.get_capture) begin
         rval_in = ram_rdata;
      end
      if (ctl.scan_start_at) begin
         rd_ptr_in  = idx_wide[CNT_W-1:0];
         wr_ptr_in  = idx_wide[CNT_W-1:0];
         gone_in    = '0;
         pend_in    = 1'b0;
         mode_at_in = 1'b1;
      end
      if (ctl.scan_start_val) begin
         rd_ptr_in  = '0;
         wr_ptr_in  = '0;
         gone_in    = '0;
         pend_in    = 1'b0;
         mode_at_in = 1'b0;
      end
      if (ctl.scan_run) begin
         issue       = (rd_ptr_ff < count_ff);
         pend_in     = issue;
         pend_pos_in = rd_ptr_ff[ADDR_W-1:0];
         if (issue) begin
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
         end
         if (pend_ff) begin
            drop = mode_at_ff ? (pend_pos_ff == idx_addr) : (ram_rdata == value_ff);
            if (drop) begin
               gone_in = gone_ff + CNT_W'(1);
            end else begin
               ram_we    = 1'b1;
               ram_waddr = wr_ptr_ff[ADDR_W-1:0];
               ram_wdata = ram_rdata;
               wr_ptr_in = wr_ptr_ff + CNT_W'(1);
            end
         end
      end
      if (ctl.scan_finish) begin
         count_in   = wr_ptr_ff;
         removed_in = gone_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      index_ff    <= index_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      gone_ff     <= gone_in;
      pend_pos_ff <= pend_pos_in;
      mode_at_ff  <= mode_at_in;
      rval_ff     <= rval_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
   end

   cle_ram #(
      .WIDTH (cle_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_read_value = rval_ff;
   assign rsp_count      = count_ff;
   assign rsp_removed    = removed_ff;
   assign rsp_status     = status_ff;

endmodule

// ===== hw/rtl/cle_checker.sv =====
// Port-level checks for compacting_list_engine, bound to the top level.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_checker #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [cle_pkg::CMD_W-1:0]         req_cmd,
   input logic signed [cle_pkg::DATA_W-1:0] req_value,
   input logic [cle_pkg::IDX_W-1:0]         req_index,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [cle_pkg::DATA_W-1:0] rsp_read_value,
   input logic [$clog2(CAPACITY+1)-1:0]     rsp_count,
   input logic [$clog2(CAPACITY+1)-1:0]     rsp_removed,
   input logic [cle_pkg::STAT_W-1:0]        rsp_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_count) && $stable(rsp_removed) && $stable(rsp_status))
      else $error("response word changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken before response");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cle_pkg::ST_FULL) |->
         (rsp_removed == '0) && (rsp_read_value == '0)
         && (rsp_count == CNT_W'(CAPACITY)))
      else $error("full status with inconsistent response word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CNT_W'(CAPACITY)) && (rsp_removed <= CNT_W'(CAPACITY)))
      else $error("count or removed beyond capacity");

endmodule

bind compacting_list_engine cle_checker #(.CAPACITY(CAPACITY)) u_cle_checker (.*);

// ===== tb/list_mirror_checker.sv =====
// Reply checker for compacting_list_engine: mirrors the list for every accepted
// request word and compares each reply word, field by field, in order.
// Depends on cle_pkg; instantiated by testbench beside the block.
`timescale 1ns / 1ps

module list_mirror_checker #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [cle_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [cle_pkg::DATA_W-1:0] req_value,
   input  logic [cle_pkg::IDX_W-1:0]         req_index,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [cle_pkg::DATA_W-1:0] rsp_read_value,
   input  logic [CNT_W-1:0]                  rsp_count,
   input  logic [CNT_W-1:0]                  rsp_removed,
   input  logic [cle_pkg::STAT_W-1:0]        rsp_status,
   output int                                mismatches,
   output int                                outstanding,
   output int                                replies_checked,
   output int                                full_refusals,
   output int                                range_errors,
   output int                                words_removed
);

   localparam int DATA_W = cle_pkg::DATA_W;
   localparam int IDX_W  = cle_pkg::IDX_W;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_W-1:0]         count;
      logic [CNT_W-1:0]         removed;
      cle_pkg::status_type      status;
   } reply_type;

   logic signed [DATA_W-1:0] list_words [0:CAPACITY-1];
   int unsigned              list_len = 0;
   reply_type                pending_replies [$];
   int                       err_total = 0;
   int                       checked_total = 0;
   int                       full_total = 0;
   int                       range_total = 0;
   int                       removed_total = 0;

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      replies_checked = 0;
      full_refusals   = 0;
      range_errors    = 0;
      words_removed   = 0;
   end

   task automatic run_list_command(input cle_pkg::op_type op,
                                   input logic signed [DATA_W-1:0] value,
                                   input logic [IDX_W-1:0] index, output reply_type res);
      int unsigned kept;
      res        = '0;
      res.status = cle_pkg::ST_OK;
      kept       = 0;
      case (op)
         cle_pkg::OP_APPEND: begin
            if (list_len >= CAPACITY) begin
               res.status = cle_pkg::ST_FULL;
            end else begin
               list_words[list_len] = value;
               list_len++;
            end
         end
         cle_pkg::OP_DELETE_AT: begin
            if (index >= list_len) begin
               res.status = cle_pkg::ST_RANGE;
            end else begin
               for (int i = index; i + 1 < list_len; i++)
                  list_words[i] = list_words[i + 1];
               list_len--;
               res.removed = CNT_W'(1);
            end
         end
         cle_pkg::OP_DELETE_VALUE: begin
            for (int i = 0; i < list_len; i++) begin
               if (list_words[i] != value) begin
                  list_words[kept] = list_words[i];
                  kept++;
               end
            end
            res.removed = CNT_W'(list_len - kept);
            list_len    = kept;
         end
         default: begin
            if (index >= list_len)
               res.status = cle_pkg::ST_RANGE;
            else
               res.read_value = list_words[index];
         end
      endcase
      res.count = CNT_W'(list_len);
   endtask

   always @(posedge clock) begin
      reply_type want;
      reply_type next_reply;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               $error("reply word with no command outstanding");
               err_total++;
            end else begin
               want = pending_replies.pop_front();
               checked_total++;
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
                  err_total++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  err_total++;
               end
               if (rsp_removed !== want.removed) begin
                  $error("removed: expected %0d, got %0d", want.removed, rsp_removed);
                  err_total++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  err_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            run_list_command(cle_pkg::op_type'(req_cmd), req_value, req_index, next_reply);
            if (next_reply.status == cle_pkg::ST_FULL)
               full_total++;
            if (next_reply.status == cle_pkg::ST_RANGE)
               range_total++;
            removed_total += next_reply.removed;
            pending_replies.push_back(next_reply);
         end
      end
      mismatches      <= err_total;
      outstanding     <= pending_replies.size();
      replies_checked <= checked_total;
      full_refusals   <= full_total;
      range_errors    <= range_total;
      words_removed   <= removed_total;
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the compacting_list_engine testbench: clock, reset, request stimulus,
// reply back-pressure, watchdog and verdict. Depends on cle_pkg, the block
// and list_mirror_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int DATA_W       = cle_pkg::DATA_W;
   localparam int IDX_W        = cle_pkg::IDX_W;
   localparam int CMD_W        = cle_pkg::CMD_W;
   localparam int STAT_W       = cle_pkg::STAT_W;
   localparam int CNT_W        = $clog2(cle_pkg::CAPACITY_DEF + 1);
   localparam int RANDOM_WORDS = 2000;
   localparam int QUIET_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = cle_pkg::CAPACITY_DEF + 8;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd;
   logic signed [DATA_W-1:0] req_value;
   logic [IDX_W-1:0]         req_index;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [CNT_W-1:0]         rsp_count;
   logic [CNT_W-1:0]         rsp_removed;
   logic [STAT_W-1:0]        rsp_status;

   int mismatches;
   int outstanding;
   int replies_checked;
   int full_refusals;
   int range_errors;
   int words_removed;

   int words_sent = 0;
   int send_calm = 0;
   int recv_calm = 0;
   int quiet_cycles = 0;
   logic wrapping_up = 1'b0;

   logic signed [DATA_W-1:0] fill_words [0:15] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
      32'sh0000_0005, 32'sh0000_0005, 32'sh0000_0005, 32'sh0000_0011,
      -32'sd17,       32'sh0000_0005, 32'sh0000_FFFF, 32'shFFFF_0000,
      32'sh0000_0005, 32'sh0000_0005, 32'sh0000_0001, 32'sh5555_5555
   };
   logic signed [DATA_W-1:0] value_pool [0:7];

   compacting_list_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_removed    (rsp_removed),
      .rsp_status     (rsp_status)
   );

   list_mirror_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_count       (rsp_count),
      .rsp_removed     (rsp_removed),
      .rsp_status      (rsp_status),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .replies_checked (replies_checked),
      .full_refusals   (full_refusals),
      .range_errors    (range_errors),
      .words_removed   (words_removed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle cycles before the next word; occasional runs with no idling at all
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   task automatic send_word(input cle_pkg::op_type op, input logic signed [DATA_W-1:0] value,
                            input logic [IDX_W-1:0] index);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= op;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   function automatic logic signed [DATA_W-1:0] pool_word();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // reply side back-pressure
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_wait(recv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && !wrapping_up) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int   roll;
      int   phase_left;
      logic filling;
      cle_pkg::op_type op;
      logic signed [DATA_W-1:0] value;

      phase_left = 0;
      filling    = 1'b1;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_cmd   <= cle_pkg::OP_APPEND;
      req_value <= '0;
      req_index <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list, fill to capacity, overflow, then edge positions
      send_word(cle_pkg::OP_GET, 0, IDX_W'(0));
      send_word(cle_pkg::OP_DELETE_AT, 0, IDX_W'(0));
      send_word(cle_pkg::OP_DELETE_VALUE, 0, IDX_W'(0));
      for (int i = 0; i < 16; i++)
         send_word(cle_pkg::OP_APPEND, fill_words[i], IDX_W'(i));
      send_word(cle_pkg::OP_APPEND, 32'sh1234_5678, IDX_W'(0));
      send_word(cle_pkg::OP_GET, 0, IDX_W'(15));
      send_word(cle_pkg::OP_GET, 0, IDX_W'(0));
      send_word(cle_pkg::OP_DELETE_VALUE, 5, IDX_W'(0));
      send_word(cle_pkg::OP_GET, 0, IDX_W'(10));
      send_word(cle_pkg::OP_DELETE_AT, 0, IDX_W'(9));
      send_word(cle_pkg::OP_DELETE_AT, 0, IDX_W'(0));
      send_word(cle_pkg::OP_DELETE_VALUE, 12345, IDX_W'(0));

      // random traffic: alternating fill and drain phases over a small value pool
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 200 == 0) begin
            for (int j = 0; j < 8; j++)
               value_pool[j] = pool_word();
         end
         if (phase_left == 0) begin
            filling    = ~filling;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (filling)
            op = roll < 65 ? cle_pkg::OP_APPEND : roll < 75 ? cle_pkg::OP_DELETE_AT :
                 roll < 85 ? cle_pkg::OP_DELETE_VALUE : cle_pkg::OP_GET;
         else
            op = roll < 25 ? cle_pkg::OP_APPEND : roll < 55 ? cle_pkg::OP_DELETE_AT :
                 roll < 65 ? cle_pkg::OP_DELETE_VALUE : cle_pkg::OP_GET;
         value = ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, 7)]
                                             : $urandom;
         send_word(op, value, IDX_W'($urandom_range(0, 15)));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      wrapping_up = 1'b1;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d commands issued, %0d replies checked", words_sent, replies_checked);
      $display("%0d appends refused as full, %0d out-of-range commands, %0d words removed",
               full_refusals, range_errors, words_removed);
      if (outstanding != 0)
         $error("%0d replies never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== compacting_list_engine.f =====
hw/rtl/cle_pkg.sv
hw/rtl/cle_ram.sv
hw/rtl/cle_ctrl.sv
hw/rtl/cle_datapath.sv
hw/rtl/compacting_list_engine.sv
hw/rtl/cle_checker.sv
tb/list_mirror_checker.sv
tb/testbench.sv
